### rtl/sbh_pkg.sv
// SHA-256 byte stream hasher: shared types, round constants and sigma functions.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package sbh_pkg;

  typedef struct packed {
    logic         last_blk;
    logic [511:0] data;
  } blk_t;

  typedef struct packed {
    logic         valid;
    logic [255:0] words;
  } digest_t;

  localparam logic [255:0] HASH_INIT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

### rtl/sha256_byte_stream_hasher.sv
// SHA-256 over a byte stream. Each input transfer carries at most one byte;
// end_of_message closes the message and eight digest words follow, word 0 first,
// last_word on word 7. The round engine takes each 64-byte block through load,
// 64 rounds and final add; bytes flow at one per cycle until the block queue is
// full. Closing a message costs one or two padding blocks, and full stays high
// while they are built.
// One digest waits in the output stage while the next message is already taken in.
// Depends on sbh_pkg, sbh_front, sbh_blk_fifo, sbh_core and sbh_out.
`timescale 1ns / 1ps
`default_nettype none

module sha256_byte_stream_hasher import sbh_pkg::*; #(
  parameter int unsigned BLOCK_QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        end_of_message,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_empty;
  blk_t    q_wr;
  blk_t    q_rd;
  logic    out_ready;
  digest_t digest;

  sbh_front u_front (
    .clk            (clk),
    .rst            (rst),
    .data_byte      (data_byte),
    .byte_valid     (byte_valid),
    .end_of_message (end_of_message),
    .push           (push),
    .full           (full),
    .q_push         (q_push),
    .q_data         (q_wr),
    .q_full         (q_full)
  );

  sbh_blk_fifo #(
    .DEPTH (BLOCK_QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd),
    .empty   (q_empty)
  );

  sbh_core u_core (
    .clk       (clk),
    .rst       (rst),
    .q_data    (q_rd),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_ready (out_ready),
    .digest    (digest)
  );

  sbh_out u_out (
    .clk         (clk),
    .rst         (rst),
    .digest      (digest),
    .ready       (out_ready),
    .pop         (pop),
    .empty       (empty),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

endmodule

`default_nettype wire

### rtl/sbh_front.sv
// Front end: packs message bytes into 64-byte blocks and builds the padding blocks.
// Depends on sbh_pkg; feeds the block queue.
`timescale 1ns / 1ps
`default_nettype none

module sbh_front import sbh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] data_byte,
  input  logic       byte_valid,
  input  logic       end_of_message,
  input  logic       push,
  output logic       full,
  output logic       q_push,
  output blk_t       q_data,
  input  logic       q_full
);

  typedef enum logic [1:0] {S_TAKE, S_PAD, S_LEN} state_t;

  state_t       state;
  logic [511:0] blk;
  logic [5:0]   fill;
  logic [63:0]  msg_len;

  logic         take;
  logic [63:0]  bit_len;
  logic [511:0] blk_merged;
  logic [511:0] blk_pad;

  assign bit_len = {msg_len[60:0], 3'b000};
  assign full    = (state != S_TAKE) || (q_full && (fill == 6'd63));
  assign take    = push && !full;

  always_comb begin
    blk_merged = blk;
    blk_merged[{~fill, 3'b111} -: 8] = data_byte;
  end

  always_comb begin
    for (int i = 0; i < 64; i++) begin
      if (6'(i) < fill) begin
        blk_pad[511 - 8*i -: 8] = blk[511 - 8*i -: 8];
      end else if (6'(i) == fill) begin
        blk_pad[511 - 8*i -: 8] = 8'h80;
      end else begin
        blk_pad[511 - 8*i -: 8] = 8'h00;
      end
    end
    if (fill <= 6'd55) begin
      blk_pad[63:0] = bit_len;
    end
  end

  always_comb begin
    q_push          = 1'b0;
    q_data.last_blk = 1'b0;
    q_data.data     = blk_merged;
    unique case (state)
      S_TAKE: begin
        q_push = take && byte_valid && (fill == 6'd63);
      end
      S_PAD: begin
        q_push          = !q_full;
        q_data.data     = blk_pad;
        q_data.last_blk = (fill <= 6'd55);
      end
      S_LEN: begin
        q_push          = !q_full;
        q_data.data     = {448'b0, bit_len};
        q_data.last_blk = 1'b1;
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_TAKE;
      fill    <= '0;
      msg_len <= '0;
    end else begin
      unique case (state)
        S_TAKE: begin
          if (take) begin
            if (byte_valid) begin
              msg_len <= msg_len + 64'd1;
              fill    <= fill + 6'd1;
              blk[{~fill, 3'b111} -: 8] <= data_byte;
            end
            if (end_of_message) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          if (!q_full) begin
            if (fill <= 6'd55) begin
              fill    <= '0;
              msg_len <= '0;
              state   <= S_TAKE;
            end else begin
              state <= S_LEN;
            end
          end
        end
        S_LEN: begin
          if (!q_full) begin
            fill    <= '0;
            msg_len <= '0;
            state   <= S_TAKE;
          end
        end
        default: begin
          state <= S_TAKE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/sbh_blk_fifo.sv
// Block queue between front end and round engine: DEPTH entries, each a 512-bit block plus a last-block flag.
// Depends on sbh_pkg for the block type.
`timescale 1ns / 1ps
`default_nettype none

module sbh_blk_fifo import sbh_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  blk_t wr_data,
  output logic full,
  input  logic pop,
  output blk_t rd_data,
  output logic empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  blk_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("block queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("block queue read while empty");

endmodule

`default_nettype wire

### rtl/sbh_core.sv
// Round engine: one SHA-256 round per cycle with a rolling 16-word schedule.
// Depends on sbh_pkg; takes blocks from the queue and hands digests to sbh_out.
`timescale 1ns / 1ps
`default_nettype none

module sbh_core import sbh_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  blk_t    q_data,
  input  logic    q_empty,
  output logic    q_pop,
  input  logic    out_ready,
  output digest_t digest
);

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_ADD} state_t;

  state_t      state;
  logic [31:0] hash [8];
  logic [31:0] v    [8];
  logic [31:0] w    [16];
  logic [5:0]  rnd;
  logic        last_blk;

  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] w_new;
  logic [31:0] sum  [8];

  assign q_pop = (state == C_IDLE) && !q_empty;

  always_comb begin
    t1 = v[7] + big_sig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[rnd] + w[0];
    t2 = big_sig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    w_new = w[0] + small_sig0(w[1]) + w[9] + small_sig1(w[14]);
    for (int i = 0; i < 8; i++) begin
      sum[i] = hash[i] + v[i];
    end
  end

  assign digest.valid = (state == C_ADD) && last_blk && out_ready;
  assign digest.words = {sum[0], sum[1], sum[2], sum[3], sum[4], sum[5], sum[6], sum[7]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= C_IDLE;
      rnd      <= '0;
      last_blk <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        hash[i] <= HASH_INIT[255 - 32*i -: 32];
      end
    end else begin
      unique case (state)
        C_IDLE: begin
          if (q_pop) begin
            for (int j = 0; j < 16; j++) begin
              w[j] <= q_data.data[511 - 32*j -: 32];
            end
            for (int i = 0; i < 8; i++) begin
              v[i] <= hash[i];
            end
            last_blk <= q_data.last_blk;
            rnd      <= '0;
            state    <= C_RUN;
          end
        end
        C_RUN: begin
          v[7] <= v[6];
          v[6] <= v[5];
          v[5] <= v[4];
          v[4] <= v[3] + t1;
          v[3] <= v[2];
          v[2] <= v[1];
          v[1] <= v[0];
          v[0] <= t1 + t2;
          for (int j = 0; j < 15; j++) begin
            w[j] <= w[j+1];
          end
          w[15] <= w_new;
          rnd   <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            state <= C_ADD;
          end
        end
        C_ADD: begin
          if (!last_blk) begin
            for (int i = 0; i < 8; i++) begin
              hash[i] <= sum[i];
            end
            state <= C_IDLE;
          end else if (out_ready) begin
            for (int i = 0; i < 8; i++) begin
              hash[i] <= HASH_INIT[255 - 32*i -: 32];
            end
            state <= C_IDLE;
          end
        end
        default: begin
          state <= C_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/sbh_out.sv
// Digest output stage: holds one digest and presents its eight words in order.
// Depends on sbh_pkg for the digest hand-off type.
`timescale 1ns / 1ps
`default_nettype none

module sbh_out import sbh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  digest_t     digest,
  output logic        ready,
  input  logic        pop,
  output logic        empty,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  logic [31:0] words [8];
  logic [2:0]  idx;
  logic        busy;

  assign ready       = !busy;
  assign empty       = !busy;
  assign digest_word = words[0];
  assign word_index  = idx;
  assign last_word   = (idx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (digest.valid) begin
      for (int i = 0; i < 8; i++) begin
        words[i] <= digest.words[255 - 32*i -: 32];
      end
      idx  <= '0;
      busy <= 1'b1;
    end else if (pop && busy) begin
      for (int i = 0; i < 7; i++) begin
        words[i] <= words[i+1];
      end
      idx <= idx + 3'd1;
      if (idx == 3'd7) begin
        busy <= 1'b0;
      end
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst) digest.valid |-> !busy)
    else $error("digest loaded while previous digest still pending");

  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && busy && last_word) |=> !busy)
    else $error("output stage still busy after final word transfer");

endmodule

`default_nettype wire
